>>> design/sic_pkg.sv
// ----------------------------------------------------------------------------
// sic_pkg
// Shared types and constants for the segment intersection classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package sic_pkg;

    localparam int COORD_BITS = 16;
    localparam int DELTA_W    = COORD_BITS + 1;     // coordinate difference
    localparam int PROD_W     = 2 * DELTA_W;        // delta * delta
    localparam int CROSS_W    = PROD_W + 1;         // den / na / nb
    localparam int MAG_W      = CROSS_W;            // magnitude of den / na
    localparam int QUO_W      = DELTA_W;            // offset magnitude < 2^DELTA_W
    localparam int DIVD_W     = MAG_W + DELTA_W;    // |na| * |delta|

    typedef enum logic [1:0] {
        REL_NONE       = 2'd0,
        REL_CROSS      = 2'd1,
        REL_COINCIDENT = 2'd2,
        REL_PARALLEL   = 2'd3
    } rel_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] first_start_x;
        logic signed [COORD_BITS-1:0] first_start_y;
        logic signed [COORD_BITS-1:0] first_end_x;
        logic signed [COORD_BITS-1:0] first_end_y;
        logic signed [COORD_BITS-1:0] second_start_x;
        logic signed [COORD_BITS-1:0] second_start_y;
        logic signed [COORD_BITS-1:0] second_end_x;
        logic signed [COORD_BITS-1:0] second_end_y;
    } in_word_t;

    typedef struct packed {
        logic [1:0]                   relation;
        logic signed [COORD_BITS-1:0] cross_x;
        logic signed [COORD_BITS-1:0] cross_y;
    } out_word_t;

    // Word carried along the divider chain: two divisions share one divisor.
    typedef struct packed {
        rel_t                         rel;
        logic [MAG_W-1:0]             den_mag;
        logic [DIVD_W-1:0]            rem_x;
        logic [DIVD_W-1:0]            rem_y;
        logic [QUO_W-1:0]             quo_x;
        logic [QUO_W-1:0]             quo_y;
        logic                         neg_x;
        logic                         neg_y;
        logic signed [COORD_BITS-1:0] x1;
        logic signed [COORD_BITS-1:0] y1;
    } div_word_t;

endpackage

`default_nettype wire

>>> design/sic_front.sv
// ----------------------------------------------------------------------------
// sic_front
// Four-stage front end: deltas, cross products, classification, dividends.
// ----------------------------------------------------------------------------
`default_nettype none

module sic_front (
    input  wire logic               clk,
    input  wire logic [3:0]         en,
    input  wire sic_pkg::in_word_t  in_word,
    output sic_pkg::div_word_t      div_word
);
    import sic_pkg::*;

    // stage 0: deltas
    logic signed [DELTA_W-1:0]    dx1_reg, dy1_reg, dx2_reg, dy2_reg, ox_reg, oy_reg;
    logic signed [COORD_BITS-1:0] x1_s0_reg, y1_s0_reg;
    // stage 1: products
    logic signed [PROD_W-1:0]     p_den_a_reg, p_den_b_reg;
    logic signed [PROD_W-1:0]     p_na_a_reg, p_na_b_reg, p_nb_a_reg, p_nb_b_reg;
    logic signed [DELTA_W-1:0]    dx1_s1_reg, dy1_s1_reg;
    logic signed [COORD_BITS-1:0] x1_s1_reg, y1_s1_reg;
    // stage 2: classification
    rel_t                         rel_s2_reg;
    logic [MAG_W-1:0]             na_mag_reg, den_mag_reg;
    logic [DELTA_W-1:0]           dx1_mag_reg, dy1_mag_reg;
    logic                         neg_x_reg, neg_y_reg;
    logic signed [COORD_BITS-1:0] x1_s2_reg, y1_s2_reg;
    // stage 3
    div_word_t                    div_reg;

    logic signed [CROSS_W-1:0] den, na, nb;
    logic                      na_ok, nb_ok;
    rel_t                      rel_next;

    assign den = CROSS_W'(p_den_a_reg) - CROSS_W'(p_den_b_reg);
    assign na  = CROSS_W'(p_na_a_reg) - CROSS_W'(p_na_b_reg);
    assign nb  = CROSS_W'(p_nb_a_reg) - CROSS_W'(p_nb_b_reg);

    // parameter in [0,1] without division
    assign na_ok = (den > 0) ? (na >= 0 && na <= den) : (na <= 0 && na >= den);
    assign nb_ok = (den > 0) ? (nb >= 0 && nb <= den) : (nb <= 0 && nb >= den);

    always_comb
    begin
        if (den == '0)
        begin
            rel_next = (na == '0 && nb == '0) ? REL_COINCIDENT : REL_PARALLEL;
        end
        else if (na_ok && nb_ok)
        begin
            rel_next = REL_CROSS;
        end
        else
        begin
            rel_next = REL_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dx1_reg   <= DELTA_W'(in_word.first_end_x)  - DELTA_W'(in_word.first_start_x);
            dy1_reg   <= DELTA_W'(in_word.first_end_y)  - DELTA_W'(in_word.first_start_y);
            dx2_reg   <= DELTA_W'(in_word.second_end_x) - DELTA_W'(in_word.second_start_x);
            dy2_reg   <= DELTA_W'(in_word.second_end_y) - DELTA_W'(in_word.second_start_y);
            ox_reg    <= DELTA_W'(in_word.first_start_x) - DELTA_W'(in_word.second_start_x);
            oy_reg    <= DELTA_W'(in_word.first_start_y) - DELTA_W'(in_word.second_start_y);
            x1_s0_reg <= in_word.first_start_x;
            y1_s0_reg <= in_word.first_start_y;
        end
        if (en[1])
        begin
            p_den_a_reg <= PROD_W'(dy2_reg) * PROD_W'(dx1_reg);
            p_den_b_reg <= PROD_W'(dx2_reg) * PROD_W'(dy1_reg);
            p_na_a_reg  <= PROD_W'(dx2_reg) * PROD_W'(oy_reg);
            p_na_b_reg  <= PROD_W'(dy2_reg) * PROD_W'(ox_reg);
            p_nb_a_reg  <= PROD_W'(dx1_reg) * PROD_W'(oy_reg);
            p_nb_b_reg  <= PROD_W'(dy1_reg) * PROD_W'(ox_reg);
            dx1_s1_reg  <= dx1_reg;
            dy1_s1_reg  <= dy1_reg;
            x1_s1_reg   <= x1_s0_reg;
            y1_s1_reg   <= y1_s0_reg;
        end
        if (en[2])
        begin
            rel_s2_reg  <= rel_next;
            na_mag_reg  <= (na < 0)  ? MAG_W'(-na)  : MAG_W'(na);
            den_mag_reg <= (den < 0) ? MAG_W'(-den) : MAG_W'(den);
            dx1_mag_reg <= (dx1_s1_reg < 0) ? DELTA_W'(-dx1_s1_reg) : DELTA_W'(dx1_s1_reg);
            dy1_mag_reg <= (dy1_s1_reg < 0) ? DELTA_W'(-dy1_s1_reg) : DELTA_W'(dy1_s1_reg);
            neg_x_reg   <= (na < 0) ^ (dx1_s1_reg < 0) ^ (den < 0);
            neg_y_reg   <= (na < 0) ^ (dy1_s1_reg < 0) ^ (den < 0);
            x1_s2_reg   <= x1_s1_reg;
            y1_s2_reg   <= y1_s1_reg;
        end
        if (en[3])
        begin
            div_reg.rel     <= rel_s2_reg;
            div_reg.den_mag <= den_mag_reg;
            div_reg.rem_x   <= DIVD_W'(na_mag_reg) * DIVD_W'(dx1_mag_reg);
            div_reg.rem_y   <= DIVD_W'(na_mag_reg) * DIVD_W'(dy1_mag_reg);
            div_reg.quo_x   <= '0;
            div_reg.quo_y   <= '0;
            div_reg.neg_x   <= neg_x_reg;
            div_reg.neg_y   <= neg_y_reg;
            div_reg.x1      <= x1_s2_reg;
            div_reg.y1      <= y1_s2_reg;
        end
    end

    assign div_word = div_reg;

endmodule

`default_nettype wire

>>> design/sic_div_cell.sv
// ----------------------------------------------------------------------------
// sic_div_cell
// One restoring-division step for both coordinates: one quotient bit each.
// ----------------------------------------------------------------------------
`default_nettype none

module sic_div_cell #(
    parameter int SHIFT = 0
) (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire sic_pkg::div_word_t prev,
    output sic_pkg::div_word_t      next
);
    import sic_pkg::*;

    div_word_t         cell_reg;
    div_word_t         cell_next;
    logic [DIVD_W-1:0] dsh;

    assign dsh = DIVD_W'(prev.den_mag) << SHIFT;

    always_comb
    begin
        cell_next = prev;
        if (prev.rem_x >= dsh)
        begin
            cell_next.rem_x        = prev.rem_x - dsh;
            cell_next.quo_x[SHIFT] = 1'b1;
        end
        if (prev.rem_y >= dsh)
        begin
            cell_next.rem_y        = prev.rem_y - dsh;
            cell_next.quo_y[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign next = cell_reg;

endmodule

`default_nettype wire

>>> design/segment_intersection_classifier.sv
// ----------------------------------------------------------------------------
// segment_intersection_classifier
// Classifies two 2D segments and gives their exact integer crossing point.
// ----------------------------------------------------------------------------
// Takes one pair of segments per word and returns one word per pair, in order.
// Throughput is one word per cycle while out_ready stays high. A word passes
// through 4 + 17 + 1 = 22 register stages: four front stages (deltas,
// cross products, classification, dividend products), a chain of 17
// division cells that each resolve one quotient bit for both x and y, and
// the output register. Every stage holds its word until the next stage can
// take it, so bubbles collapse and in_ready stays high while a finished
// word waits on out_ready as long as any stage is free. relation: 0 none,
// 1 crossing, 2 coincident, 3 parallel; cross_x/cross_y are zero unless
// relation is crossing, and are truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection_classifier (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire sic_pkg::in_word_t  in_word,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output sic_pkg::out_word_t      out_word
);
    import sic_pkg::*;

    localparam int FRONT  = 4;
    localparam int STAGES = FRONT + QUO_W;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES:0]   en;
    logic              out_valid_reg;
    out_word_t         out_reg;
    div_word_t         chain [QUO_W+1];

    // a stage moves when it is empty or its successor moves
    always_comb
    begin
        en[STAGES] = !out_valid_reg || out_ready;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
            if (en[STAGES])
            begin
                out_valid_reg <= valid_reg[STAGES-1];
            end
        end
    end

    sic_front u_front (
        .clk      (clk),
        .en       (en[FRONT-1:0]),
        .in_word  (in_word),
        .div_word (chain[0])
    );

    // MSB quotient bit first
    for (genvar i = 0; i < QUO_W; i++)
    begin : g_cell
        sic_div_cell #(
            .SHIFT (QUO_W - 1 - i)
        ) u_cell (
            .clk  (clk),
            .en   (en[FRONT+i]),
            .prev (chain[i]),
            .next (chain[i+1])
        );
    end

    // sign and start-point add
    div_word_t                  last;
    logic signed [QUO_W:0]      off_x, off_y;
    logic signed [COORD_BITS+1:0] px, py;
    out_word_t                  out_next;

    assign last  = chain[QUO_W];
    assign off_x = last.neg_x ? -$signed({1'b0, last.quo_x}) : $signed({1'b0, last.quo_x});
    assign off_y = last.neg_y ? -$signed({1'b0, last.quo_y}) : $signed({1'b0, last.quo_y});
    assign px    = (COORD_BITS+2)'(last.x1) + (COORD_BITS+2)'(off_x);
    assign py    = (COORD_BITS+2)'(last.y1) + (COORD_BITS+2)'(off_y);

    always_comb
    begin
        out_next.relation = last.rel;
        out_next.cross_x  = '0;
        out_next.cross_y  = '0;
        if (last.rel == REL_CROSS)
        begin
            out_next.cross_x = px[COORD_BITS-1:0];
            out_next.cross_y = py[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[STAGES])
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

`default_nettype wire

>>> tb/tb_segment_intersection_classifier.sv
// ----------------------------------------------------------------------------
// tb_segment_intersection_classifier
// Self-checking bench for the segment intersection classifier.
// ----------------------------------------------------------------------------
// Segment pairs go in through a bursty driver and results come out through a
// receiver with its own stall pattern. Each accepted pair is classified by a
// behavioral predictor working at full integer width. The expected word is
// queued, and every output word is checked against the oldest queued word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_segment_intersection_classifier;

    import sic_pkg::*;

    localparam int N_RANDOM = 400;
    localparam int WATCHDOG = 2000;
    localparam int DRAIN    = 60;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_word_t  in_word = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_word_t out_word;

    in_word_t  pending_pairs[$];
    out_word_t expected_words[$];
    int        errors = 0;
    int        idle_cycles = 0;
    bit        stim_done = 1'b0;
    int        gap_left = 0;
    int        burst_left = 0;
    int        stall_mode = 0;

    segment_intersection_classifier u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    always #5 clk = ~clk;

    // n/den within [0,1], checked by sign and magnitude
    function automatic bit in_unit_range(longint n, longint den);
        if (den > 0)
            return n >= 0 && n <= den;
        return n <= 0 && n >= den;
    endfunction

    // na*delta/den truncated toward zero; 128-bit product keeps it exact
    function automatic longint scaled_offset(longint na, longint delta, longint den);
        logic signed [127:0] prod;
        logic signed [127:0] quo;
        begin
            prod = 128'(signed'(na)) * 128'(signed'(delta));
            quo  = prod / 128'(signed'(den));
            return longint'(quo);
        end
    endfunction

    function automatic out_word_t classify_pair(in_word_t w);
        longint x1, y1, x2, y2, x3, y3, x4, y4;
        longint dx1, dy1, dx2, dy2, ox, oy, den, na, nb;
        out_word_t r;
        begin
            x1 = w.first_start_x;  y1 = w.first_start_y;
            x2 = w.first_end_x;    y2 = w.first_end_y;
            x3 = w.second_start_x; y3 = w.second_start_y;
            x4 = w.second_end_x;   y4 = w.second_end_y;
            dx1 = x2 - x1; dy1 = y2 - y1;
            dx2 = x4 - x3; dy2 = y4 - y3;
            ox = x1 - x3;  oy = y1 - y3;
            den = dy2 * dx1 - dx2 * dy1;
            na  = dx2 * oy - dy2 * ox;
            nb  = dx1 * oy - dy1 * ox;
            r = '0;
            if (den == 0) begin
                r.relation = (na == 0 && nb == 0) ? REL_COINCIDENT : REL_PARALLEL;
            end
            else if (in_unit_range(na, den) && in_unit_range(nb, den)) begin
                r.relation = REL_CROSS;
                r.cross_x  = COORD_BITS'(x1 + scaled_offset(na, dx1, den));
                r.cross_y  = COORD_BITS'(y1 + scaled_offset(na, dy1, den));
            end
            else begin
                r.relation = REL_NONE;
            end
            return r;
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        begin
            $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
            errors++;
        end
    endtask

    function automatic logic signed [COORD_BITS-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            1, 2: return COORD_BITS'($urandom_range(0, 64) - 32);
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    function automatic in_word_t make_pair(int x1, int y1, int x2, int y2,
                                           int x3, int y3, int x4, int y4);
        in_word_t w;
        begin
            w.first_start_x = COORD_BITS'(x1);  w.first_start_y = COORD_BITS'(y1);
            w.first_end_x = COORD_BITS'(x2);    w.first_end_y = COORD_BITS'(y2);
            w.second_start_x = COORD_BITS'(x3); w.second_start_y = COORD_BITS'(y3);
            w.second_end_x = COORD_BITS'(x4);   w.second_end_y = COORD_BITS'(y4);
            return w;
        end
    endfunction

    // Mostly crossing-shaped pairs: second segment straddles a point on the first.
    function automatic in_word_t rand_pair();
        in_word_t w;
        int       mx, my, ax, ay;
        begin
            if ($urandom_range(0, 2) == 0) begin
                w = in_word_t'({$urandom, $urandom, $urandom, $urandom});
                if ($urandom_range(0, 1))
                    w = make_pair(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                                  rand_coord(), rand_coord(), rand_coord(), rand_coord());
            end
            else begin
                mx = $urandom_range(0, 40000) - 20000;
                my = $urandom_range(0, 40000) - 20000;
                ax = $urandom_range(0, 24000) - 12000;
                ay = $urandom_range(0, 24000) - 12000;
                w = make_pair(mx - ax, my - ay, mx + ax, my + ay,
                              mx - ay + $urandom_range(0, 20) - 10, my + ax,
                              mx + ay, my - ax + $urandom_range(0, 20) - 10);
                if ($urandom_range(0, 7) == 0) // parallel or collinear copy
                    w = make_pair(mx - ax, my - ay, mx + ax, my + ay,
                                  mx, my + $urandom_range(0, 1) * 7, mx + ax,
                                  my + ay + $urandom_range(0, 1) * 7);
            end
            return w;
        end
    endfunction

    // Driver: bursts of random length separated by random gaps.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                expected_words.push_back(classify_pair(in_word));
            end
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_pairs.size() > 0) begin
                    in_word  <= pending_pairs.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left <= burst_left - 1;
                    else begin
                        burst_left <= $urandom_range(0, 20);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern switches between free-running, random and heavy.
    always @(posedge clk) begin
        if (rst_n) begin
            if ($urandom_range(0, 63) == 0)
                stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                default: out_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // Monitor and watchdog.
    always @(posedge clk) begin
        out_word_t want;
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WATCHDOG) begin
                $display("tb_segment_intersection_classifier NOT OK");
                $finish;
            end
            if (out_valid && out_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word", 0, 0);
                end
                else begin
                    want = expected_words.pop_front();
                    if (out_word.relation !== want.relation)
                        report_mismatch("relation", out_word.relation, want.relation);
                    if (out_word.cross_x !== want.cross_x)
                        report_mismatch("cross_x", out_word.cross_x, want.cross_x);
                    if (out_word.cross_y !== want.cross_y)
                        report_mismatch("cross_y", out_word.cross_y, want.cross_y);
                end
            end
        end
    end

    initial begin
        // Directed: extremes, each relation, degenerate segments.
        pending_pairs.push_back(make_pair(0, 0, 10, 10, 0, 10, 10, 0));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 0, 5, 10, 5));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 20, 0, 30, 0));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 5, 0, 30, 0));
        pending_pairs.push_back(make_pair(0, 0, 10, 10, 20, 0, 20, 30));
        pending_pairs.push_back(make_pair(3, 3, 3, 3, 3, 3, 3, 3));
        pending_pairs.push_back(make_pair(3, 3, 3, 3, 0, 0, 5, 7));
        pending_pairs.push_back(make_pair(0, 0, 3, 7, 1, 1, 1, 1));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 10, 0, 10, 10));
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 0, 0, 0, 10));
        pending_pairs.push_back(make_pair(0, 0, 7, 3, 1, 5, 4, -4));
        pending_pairs.push_back(make_pair(0, 0, -7, -3, -1, -5, -4, 4));
        pending_pairs.push_back(make_pair(-32768, -32768, 32767, 32767,
                                          -32768, 32767, 32767, -32768));
        pending_pairs.push_back(make_pair(32767, -32768, -32768, 32767,
                                          -32768, -32768, 32767, 32767));
        pending_pairs.push_back(make_pair(-32768, 0, 32767, 1, 0, -32768, 1, 32767));
        pending_pairs.push_back(make_pair(-32768, -32768, 32767, -32768,
                                          -32768, 32767, 32767, 32767));
        pending_pairs.push_back(make_pair(-32768, -32768, -32768, -32768,
                                          32767, 32767, 32767, 32767));
        pending_pairs.push_back(make_pair(32767, 32767, -32768, -32768,
                                          -32768, -32768, 32767, 32767));
        pending_pairs.push_back(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
        for (int i = 0; i < N_RANDOM; i++)
            pending_pairs.push_back(rand_pair());

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_pairs.size() == 0 && !in_valid);
        wait (expected_words.size() == 0);
        repeat (DRAIN) @(posedge clk);
        if (errors == 0)
            $display("tb_segment_intersection_classifier OK");
        else
            $display("tb_segment_intersection_classifier NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
design/sic_pkg.sv
design/sic_front.sv
design/sic_div_cell.sv
design/segment_intersection_classifier.sv
tb/tb_segment_intersection_classifier.sv
